// ===== rtl/core/tss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the tone segment sequencer.
package tss_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_W        = 4;

    localparam logic [11:0] FREQ_MIN  = 12'd1;
    localparam logic [11:0] FREQ_MAX  = 12'd3000;
    localparam logic [6:0]  VOL_MAX   = 7'd100;
    localparam logic [9:0]  PER_MILLE = 10'd1000;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // serial divider sizing
    localparam int DIV_REM_W  = 16;
    localparam int DIV_BITS_W = 12;
    localparam int DIV_CNT_W  = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  seg_index;
        logic [11:0] start_freq;
        logic [11:0] end_freq;
        logic [6:0]  start_vol;
        logic [6:0]  end_vol;
        logic [15:0] duration_ms;
        logic [15:0] elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [11:0] tone_freq;
        logic [6:0]  tone_vol;
        logic [3:0]  segment_now;
        logic        finished;
    } t_out;

    typedef struct packed {
        logic [11:0] start_freq;
        logic [11:0] end_freq;
        logic [6:0]  start_vol;
        logic [6:0]  end_vol;
        logic [15:0] duration_ms;
    } t_seg;

    typedef struct packed {
        logic [DIV_REM_W-1:0]  rem0;
        logic [DIV_BITS_W-1:0] bits;
        logic [DIV_REM_W-1:0]  divisor;
        logic [DIV_CNT_W-1:0]  count;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_BITS_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [11:0] clamp_freq(input logic [11:0] f);
        logic [11:0] r;
        r = f;
        if (f < FREQ_MIN) begin
            r = FREQ_MIN;
        end else if (f > FREQ_MAX) begin
            r = FREQ_MAX;
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp_vol(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v > VOL_MAX) begin
            r = VOL_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tss_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module tss_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tss_pkg::t_div_req i_req,
    output tss_pkg::t_div_rsp o_rsp
);
    import tss_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_BITS_W-1:0] r_bits;
    logic [DIV_REM_W-1:0]  r_div;
    logic [DIV_BITS_W-1:0] r_quot;

    logic [DIV_REM_W:0]    trial;
    logic [DIV_REM_W:0]    diff;
    logic                  ge;

    // caller guarantees rem0 < divisor, so the remainder stays below the divisor
    assign trial = {r_rem, r_bits[DIV_BITS_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.count;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_req.rem0;
            r_bits <= i_req.bits;
            r_div  <= i_req.divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            r_bits <= {r_bits[DIV_BITS_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_BITS_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider busy with zero count");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_div) else $error("remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a division");
`endif

endmodule

// ===== rtl/core/tone_segment_sequencer.sv =====
`timescale 1ns / 1ps
// Load, ignored and finished-tick requests go straight to the output state; start reads the table
// in S_RD and S_EVAL, a segment step or restart reads it once more. A sweeping tick makes three
// passes through one bit-serial divider (10 portion bits, 12 frequency bits, 7 volume bits).
// One request is processed at a time; a finished result may wait in the output register
// while the next request is taken. Synchronous active-low reset: idle, finished, freq 1,
// volume 0, segment 0, segment_count 1, repeat_count 0; the segment table is not cleared.
module tone_segment_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  tss_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output tss_pkg::t_out o_out_data,
    input  logic          i_out_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tss_pkg::*;

    localparam logic REG_SEG_COUNT = 1'b0;
    localparam logic REG_REPEAT    = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_RD      = 11'b000_0000_0010,
        S_EVAL    = 11'b000_0000_0100,
        S_DP_GO   = 11'b000_0000_1000,
        S_DP_WAIT = 11'b000_0001_0000,
        S_MUL     = 11'b000_0010_0000,
        S_DF_GO   = 11'b000_0100_0000,
        S_DF_WAIT = 11'b000_1000_0000,
        S_DV_GO   = 11'b001_0000_0000,
        S_DV_WAIT = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        RK_START = 2'd0,
        RK_TICK  = 2'd1,
        RK_NEXT  = 2'd2
    } t_rd_kind;

    t_seg r_mem [MAX_SEGMENTS];

    t_state      r_state, n_state;
    t_rd_kind    r_kind, n_kind;
    logic [SEG_W-1:0] r_rd_addr, n_rd_addr;
    t_seg        r_rd_data;
    logic [3:0]  r_cur, n_cur;
    logic [16:0] r_time, n_time;
    logic [7:0]  r_reps, n_reps;
    logic        r_done, n_done;
    logic [11:0] r_freq, n_freq;
    logic [6:0]  r_vol, n_vol;
    logic [25:0] r_prod, n_prod;
    logic [21:0] r_pf, n_pf;
    logic [16:0] r_pv, n_pv;
    logic        r_neg_f, n_neg_f;
    logic        r_neg_v, n_neg_v;
    logic        r_out_valid, n_out_valid;
    t_out        r_out_data, n_out_data;
    logic [4:0]  r_seg_count;
    logic [7:0]  r_rep_count;

    logic        in_acc;
    logic        cfg_wr;
    logic [4:0]  eff_count;
    logic [7:0]  reps_sat;
    logic [11:0] mag_f;
    logic [6:0]  mag_v;
    logic [9:0]  portion;
    logic [12:0] sum_f;
    logic [7:0]  sum_v;
    logic        div_start;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    tss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_SEG_COUNT: prdata = {27'b0, r_seg_count};
            REG_REPEAT:    prdata = {24'b0, r_rep_count};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= 5'd1;
            r_rep_count <= 8'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SEG_COUNT: r_seg_count <= pwdata[4:0];
                REG_REPEAT:    r_rep_count <= pwdata[7:0];
                default:       r_rep_count <= r_rep_count;
            endcase
        end
    end

    // segment table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.op == OP_LOAD
                && {1'b0, i_in_data.seg_index} < 5'(MAX_SEGMENTS)) begin
            r_mem[i_in_data.seg_index[SEG_W-1:0]] <= '{
                start_freq:  i_in_data.start_freq,
                end_freq:    i_in_data.end_freq,
                start_vol:   i_in_data.start_vol,
                end_vol:     i_in_data.end_vol,
                duration_ms: i_in_data.duration_ms
            };
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_comb begin
        if (r_seg_count == 5'd0) begin
            eff_count = 5'd1;
        end else if (r_seg_count > 5'(MAX_SEGMENTS)) begin
            eff_count = 5'(MAX_SEGMENTS);
        end else begin
            eff_count = r_seg_count;
        end
    end

    assign reps_sat = (r_reps != 8'hFF) ? r_reps + 8'd1 : r_reps;
    assign portion  = div_rsp.quot[9:0];
    assign mag_f = (r_rd_data.end_freq >= r_rd_data.start_freq)
                 ? r_rd_data.end_freq - r_rd_data.start_freq
                 : r_rd_data.start_freq - r_rd_data.end_freq;
    assign mag_v = (r_rd_data.end_vol >= r_rd_data.start_vol)
                 ? r_rd_data.end_vol - r_rd_data.start_vol
                 : r_rd_data.start_vol - r_rd_data.end_vol;
    // truncation toward zero: apply the sign after dividing the magnitude
    assign sum_f = r_neg_f ? {1'b0, r_rd_data.start_freq} - {1'b0, div_rsp.quot}
                           : {1'b0, r_rd_data.start_freq} + {1'b0, div_rsp.quot};
    assign sum_v = r_neg_v ? {1'b0, r_rd_data.start_vol} - {1'b0, div_rsp.quot[6:0]}
                           : {1'b0, r_rd_data.start_vol} + {1'b0, div_rsp.quot[6:0]};

    // quotients are known to fit, so the top dividend bits already sit below the divisor
    always_comb begin
        div_start = 1'b0;
        div_req   = '{rem0: r_prod[25:10], bits: {r_prod[9:0], 2'b0},
                      divisor: r_rd_data.duration_ms, count: DIV_CNT_W'(10)};
        case (r_state)
            S_DP_GO: begin
                div_start = 1'b1;
            end
            S_DF_GO: begin
                div_start = 1'b1;
                div_req   = '{rem0: {6'b0, r_pf[21:12]}, bits: r_pf[11:0],
                              divisor: {6'b0, PER_MILLE}, count: DIV_CNT_W'(12)};
            end
            S_DV_GO: begin
                div_start = 1'b1;
                div_req   = '{rem0: {6'b0, r_pv[16:7]}, bits: {r_pv[6:0], 5'b0},
                              divisor: {6'b0, PER_MILLE}, count: DIV_CNT_W'(7)};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_rd_addr   = r_rd_addr;
        n_cur       = r_cur;
        n_time      = r_time;
        n_reps      = r_reps;
        n_done      = r_done;
        n_freq      = r_freq;
        n_vol       = r_vol;
        n_prod      = r_prod;
        n_pf        = r_pf;
        n_pv        = r_pv;
        n_neg_f     = r_neg_f;
        n_neg_v     = r_neg_v;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_START: begin
                            n_reps    = 8'd0;
                            n_rd_addr = '0;
                            n_kind    = RK_START;
                            n_state   = S_RD;
                        end
                        OP_TICK: begin
                            if (r_done) begin
                                n_state = S_OUT;
                            end else begin
                                n_time    = r_time + {1'b0, i_in_data.elapsed_ms};
                                n_rd_addr = r_cur[SEG_W-1:0];
                                n_kind    = RK_TICK;
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_kind)
                    RK_START: begin
                        n_done  = 1'b0;
                        n_cur   = '0;
                        n_time  = '0;
                        n_freq  = clamp_freq(r_rd_data.start_freq);
                        n_state = S_OUT;
                    end
                    RK_NEXT: begin
                        n_freq  = clamp_freq(r_rd_data.start_freq);
                        n_vol   = clamp_vol(r_rd_data.start_vol);
                        n_time  = '0;
                        n_state = S_OUT;
                    end
                    default: begin
                        if (r_time < {1'b0, r_rd_data.duration_ms}) begin
                            n_prod  = {10'b0, r_time[15:0]} * {16'b0, PER_MILLE};
                            n_state = S_DP_GO;
                        end else if ({1'b0, r_cur} + 5'd1 >= eff_count) begin
                            n_reps = reps_sat;
                            if (r_rep_count == 8'd0 || reps_sat < r_rep_count) begin
                                n_rd_addr = '0;
                                n_kind    = RK_START;
                                n_state   = S_RD;
                            end else begin
                                n_done  = 1'b1;
                                n_vol   = '0;
                                n_state = S_OUT;
                            end
                        end else begin
                            n_cur     = r_cur + 4'd1;
                            n_rd_addr = r_cur[SEG_W-1:0] + SEG_W'(1);
                            n_kind    = RK_NEXT;
                            n_state   = S_RD;
                        end
                    end
                endcase
            end
            S_DP_GO: begin
                n_state = S_DP_WAIT;
            end
            S_DP_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_pf    = {12'b0, portion} * {10'b0, mag_f};
                n_pv    = {7'b0, portion} * {10'b0, mag_v};
                n_neg_f = r_rd_data.end_freq < r_rd_data.start_freq;
                n_neg_v = r_rd_data.end_vol < r_rd_data.start_vol;
                n_state = S_DF_GO;
            end
            S_DF_GO: begin
                n_state = S_DF_WAIT;
            end
            S_DF_WAIT: begin
                if (div_rsp.done) begin
                    n_freq  = clamp_freq(sum_f[11:0]);
                    n_state = S_DV_GO;
                end
            end
            S_DV_GO: begin
                n_state = S_DV_WAIT;
            end
            S_DV_WAIT: begin
                if (div_rsp.done) begin
                    n_vol   = clamp_vol(sum_v[6:0]);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{tone_freq: r_freq, tone_vol: r_vol,
                                    segment_now: r_cur, finished: r_done};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= RK_START;
            r_rd_addr   <= '0;
            r_cur       <= '0;
            r_time      <= '0;
            r_reps      <= '0;
            r_done      <= 1'b1;
            r_freq      <= FREQ_MIN;
            r_vol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_rd_addr   <= n_rd_addr;
            r_cur       <= n_cur;
            r_time      <= n_time;
            r_reps      <= n_reps;
            r_done      <= n_done;
            r_freq      <= n_freq;
            r_vol       <= n_vol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_pf       <= n_pf;
        r_pv       <= n_pv;
        r_neg_f    <= n_neg_f;
        r_neg_v    <= n_neg_v;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_muted_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_vol == 7'd0) else $error("finished but not muted");
    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_freq >= FREQ_MIN && r_freq <= FREQ_MAX) else $error("held freq out of range");
    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol <= VOL_MAX) else $error("held volume out of range");
    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_out_valid) && r_out_valid |-> $past(r_state) == S_OUT)
        else $error("result loaded outside output state");
`endif

endmodule

// ===== test/tone_segment_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tone segment sequencer: playback predictor, random traffic.
module tone_segment_sequencer_tb;
    import tss_pkg::*;

    localparam logic [1:0] OP_NONE            = 2'd3;
    localparam logic [2:0] ADDR_SEGMENT_COUNT = 3'd0;
    localparam logic [2:0] ADDR_REPEAT_COUNT  = 3'd4;
    localparam int         PLAYS_MAX          = 255;
    localparam int         STUCK_LIMIT        = 5000;
    localparam int         DRAIN_CYCLES       = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the player
    t_seg        seg_table [MAX_SEGMENTS];
    logic [4:0]  cfg_seg_count = 5'd1;
    logic [7:0]  cfg_repeats   = 8'd0;
    int          play_seg      = 0;
    int          play_time     = 0;
    int          plays_done    = 0;
    logic        play_done     = 1'b1;
    logic [11:0] tone_freq_q   = 12'd1;
    logic [6:0]  tone_vol_q    = 7'd0;

    t_out        tone_expected [$];
    t_out        tone_wanted;
    int          mismatch_count = 0;
    int          stuck_cycles   = 0;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;

    tone_segment_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 clk = ~clk;

    function automatic logic [11:0] fit_freq(input longint f);
        if (f < 1) return 12'd1;
        if (f > longint'(FREQ_MAX)) return FREQ_MAX;
        return f[11:0];
    endfunction

    function automatic logic [6:0] fit_vol(input longint v);
        if (v < 0) return 7'd0;
        if (v > longint'(VOL_MAX)) return VOL_MAX;
        return v[6:0];
    endfunction

    // linear sweep, truncating toward zero
    function automatic longint ramp(input longint portion, input longint a, input longint b);
        return portion * (b - a) / longint'(PER_MILLE) + a;
    endfunction

    function automatic int active_segments();
        if (cfg_seg_count == 0) return 1;
        if (cfg_seg_count > MAX_SEGMENTS) return MAX_SEGMENTS;
        return int'(cfg_seg_count);
    endfunction

    function automatic void restart_melody();
        play_done   = 1'b0;
        play_seg    = 0;
        play_time   = 0;
        tone_freq_q = fit_freq(longint'(seg_table[0].start_freq));
    endfunction

    function automatic t_out predict_tone(input t_in req);
        t_out   res;
        t_seg   cur;
        longint portion;
        case (req.op)
            OP_LOAD: begin
                seg_table[req.seg_index] = '{req.start_freq, req.end_freq, req.start_vol,
                                             req.end_vol, req.duration_ms};
            end
            OP_START: begin
                plays_done = 0;
                restart_melody();
            end
            OP_TICK: begin
                if (!play_done) begin
                    play_time += int'(req.elapsed_ms);
                    cur = seg_table[play_seg];
                    if (play_time < int'(cur.duration_ms)) begin
                        portion = longint'(play_time) * longint'(PER_MILLE)
                                  / longint'(cur.duration_ms);
                        tone_freq_q = fit_freq(ramp(portion, cur.start_freq, cur.end_freq));
                        tone_vol_q  = fit_vol(ramp(portion, cur.start_vol, cur.end_vol));
                    end else if (play_seg + 1 >= active_segments()) begin
                        if (plays_done < PLAYS_MAX) plays_done++;
                        if (cfg_repeats == 0 || plays_done < int'(cfg_repeats)) begin
                            restart_melody();
                        end else begin
                            play_done  = 1'b1;
                            tone_vol_q = 7'd0;
                        end
                    end else begin
                        play_seg++;
                        cur         = seg_table[play_seg];
                        tone_freq_q = fit_freq(longint'(cur.start_freq));
                        tone_vol_q  = fit_vol(longint'(cur.start_vol));
                        play_time   = 0;
                    end
                end
            end
            default: ;
        endcase
        res.tone_freq   = tone_freq_q;
        res.tone_vol    = tone_vol_q;
        res.segment_now = 4'(play_seg);
        res.finished    = play_done;
        return res;
    endfunction

    // unused fields carry random junk
    function automatic t_in noise_request(input logic [1:0] op);
        t_in         r;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(t_in)-1:0];
        r.op = op;
        return r;
    endfunction

    function automatic t_in load_request(input logic [3:0] idx, input logic [11:0] sf,
                                         input logic [11:0] ef, input logic [6:0] sv,
                                         input logic [6:0] ev, input logic [15:0] dur);
        t_in r;
        r = noise_request(OP_LOAD);
        r.seg_index   = idx;
        r.start_freq  = sf;
        r.end_freq    = ef;
        r.start_vol   = sv;
        r.end_vol     = ev;
        r.duration_ms = dur;
        return r;
    endfunction

    function automatic t_in tick_request(input logic [15:0] elapsed);
        t_in r;
        r = noise_request(OP_TICK);
        r.elapsed_ms = elapsed;
        return r;
    endfunction

    function automatic logic [15:0] pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'd0;
        if (roll < 15) return 16'($urandom);
        if (roll < 35) return 16'($urandom_range(1, 100));
        return 16'($urandom_range(1, 1500));
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 16'd0;
        if (roll < 15) return 16'($urandom);
        if (roll < 30) return 16'($urandom_range(0, 2000));
        return 16'($urandom_range(0, 300));
    endfunction

    function automatic t_in random_load();
        return load_request(4'($urandom), 12'($urandom), 12'($urandom), 7'($urandom),
                            7'($urandom), pick_duration());
    endfunction

    // mostly ticks through a running melody; restart soon after it ends
    function automatic t_in next_playback_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (play_done && roll < 50) return noise_request(OP_START);
        if (roll < 3) return noise_request(OP_NONE);
        if (roll < 13) return random_load();
        if (roll < 17) return noise_request(OP_START);
        return tick_request(pick_elapsed());
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic send_request(input t_in req);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        tone_expected.push_back(predict_tone(req));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (tone_expected.size() != 0) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic configure_player(input logic [4:0] seg_count, input logic [7:0] repeats);
        logic [31:0] readback;
        drain_results();
        apb_access(1'b1, ADDR_SEGMENT_COUNT, 32'(seg_count), readback);
        apb_access(1'b0, ADDR_SEGMENT_COUNT, '0, readback);
        check_field("segment_count readback", readback, 32'(seg_count));
        apb_access(1'b1, ADDR_REPEAT_COUNT, 32'(repeats), readback);
        apb_access(1'b0, ADDR_REPEAT_COUNT, '0, readback);
        check_field("repeat_count readback", readback, 32'(repeats));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_seg_count = seg_count;
        cfg_repeats   = repeats;
    endtask

    // field extremes, ignored ops, sweep both ways, zero-length segment, mute at end
    task automatic test_directed_items();
        configure_player(5'd3, 8'd1);
        send_request(tick_request(16'hFFFF));
        send_request(noise_request(OP_NONE));
        send_request(load_request(4'd0, 12'd0, 12'd4095, 7'd127, 7'd0, 16'd1000));
        send_request(load_request(4'd1, 12'd4095, 12'd0, 7'd0, 7'd127, 16'd0));
        send_request(load_request(4'd2, 12'd3000, 12'd1, 7'd100, 7'd0, 16'hFFFF));
        for (int i = 3; i < MAX_SEGMENTS; i++) begin
            send_request(load_request(4'(i), 12'($urandom), 12'($urandom), 7'($urandom),
                                      7'($urandom), pick_duration()));
        end
        send_request(noise_request(OP_START));
        send_request(tick_request(16'd0));
        send_request(tick_request(16'd500));
        send_request(tick_request(16'd600));
        send_request(tick_request(16'd0));
        send_request(tick_request(16'hFFFF));
        send_request(tick_request(16'd1));
        send_request(noise_request(OP_START));
    endtask

    // endless repeat runs the play counter into saturation, then a limit of 255 stops it
    task automatic test_repeat_saturation();
        logic [15:0] dur;
        dur = 16'($urandom_range(1, 50));
        configure_player(5'd1, 8'd0);
        send_request(load_request(4'd0, 12'($urandom), 12'($urandom), 7'($urandom),
                                  7'($urandom), dur));
        send_request(noise_request(OP_START));
        repeat (300) send_request(tick_request(16'($urandom_range(int'(dur), 65535))));
        configure_player(5'd1, 8'd255);
        send_request(tick_request(16'($urandom_range(int'(dur), 65535))));
        send_request(tick_request(pick_elapsed()));
        send_request(noise_request(OP_START));
    endtask

    task automatic test_random_playback(input int n, input logic [4:0] seg_count,
                                       input logic [7:0] repeats);
        t_in  req;
        int   counted;
        logic ignored;
        counted = 0;
        configure_player(seg_count, repeats);
        send_request(noise_request(OP_START));
        while (counted < n) begin
            req = next_playback_request();
            ignored = (req.op == OP_NONE) || (req.op == OP_TICK && play_done);
            send_request(req);
            if (!ignored) counted++;
            if ($urandom_range(0, 99) == 0) drain_results();
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (tone_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected: %p", $time, out_data);
            end else begin
                tone_wanted = tone_expected.pop_front();
                check_field("tone_freq", 32'(out_data.tone_freq),
                            32'(tone_wanted.tone_freq));
                check_field("tone_vol", 32'(out_data.tone_vol), 32'(tone_wanted.tone_vol));
                check_field("segment_now", 32'(out_data.segment_now),
                            32'(tone_wanted.segment_now));
                check_field("finished", 32'(out_data.finished), 32'(tone_wanted.finished));
            end
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
        $display("%0t: timeout, no request moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 25;
        recv_stall_pct = 65;
        test_directed_items();
        test_random_playback(200, 5'd16, 8'd2);
        test_random_playback(200, 5'd0, 8'd3);

        send_gap_pct   = 65;
        recv_stall_pct = 25;
        test_repeat_saturation();
        test_random_playback(200, 5'd31, 8'd0);
        test_random_playback(200, 5'($urandom_range(1, 16)), 8'($urandom));

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_playback(200, 5'd1, 8'd255);
        test_random_playback(200, 5'd7, 8'd1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== tone_segment_sequencer.f =====
rtl/core/tss_pkg.sv
rtl/core/tss_div.sv
rtl/core/tone_segment_sequencer.sv
test/tone_segment_sequencer_tb.sv
